@@ src/mobw_pkg.sv @@
package mobw_pkg;

  // book size and field widths
  localparam int BOOK_LEVELS = 16;
  localparam int OP_W        = 2;
  localparam int IDX_W       = 4;
  localparam int PRICE_W     = 32;
  localparam int QTY_W       = 24;
  localparam int TAG_W       = 16;
  localparam int STATUS_W    = 2;
  localparam int COST_OUT_W  = 60;

  // derived widths
  localparam int COST_W    = PRICE_W + QTY_W;
  localparam int AVG_W     = PRICE_W;
  localparam int LVL_W     = (BOOK_LEVELS > 1) ? $clog2(BOOK_LEVELS) : 1;
  localparam int CNT_W     = $clog2(BOOK_LEVELS + 1);
  localparam int DIV_CNT_W = $clog2(AVG_W);

  // operation codes
  localparam logic [OP_W-1:0] OP_WRITE_ASK = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE_BID = 2'd1;
  localparam logic [OP_W-1:0] OP_MARKET    = 2'd2;

  // fill status codes
  localparam logic [STATUS_W-1:0] FILL_FULL    = 2'd0;
  localparam logic [STATUS_W-1:0] FILL_PARTIAL = 2'd1;
  localparam logic [STATUS_W-1:0] FILL_NONE    = 2'd2;

  // one book level as stored in the ram
  typedef struct packed {
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   quantity;
  } level_t;

  // commands from controller to datapath
  typedef struct packed {
    logic write_ask;
    logic write_bid;
    logic load_order;
    logic take;
    logic accum;
    logic div_init;
    logic div_step;
    logic out_load;
  } ctrl_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic remaining_zero;
    logic walk_end;
    logic filled_zero;
    logic div_last;
  } dp_status_t;

endpackage

@@ src/mobw_ram.sv @@
module mobw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/mobw_dp.sv @@
module mobw_dp import mobw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  ctrl_cmd_t             cmd,
  output dp_status_t            status,
  input  logic                  side,
  input  logic [IDX_W-1:0]      level_index,
  input  logic [PRICE_W-1:0]    price_ticks,
  input  logic [QTY_W-1:0]      quantity,
  input  logic [TAG_W-1:0]      order_tag,
  output logic [TAG_W-1:0]      fill_tag,
  output logic                  fill_side,
  output logic [QTY_W-1:0]      filled_quantity,
  output logic [COST_OUT_W-1:0] fill_cost,
  output logic [AVG_W-1:0]      average_price,
  output logic [STATUS_W-1:0]   fill_status
);

  // order context and walk state
  logic                   side_q;
  logic [TAG_W-1:0]       tag_q;
  logic [QTY_W-1:0]       remaining;
  logic [QTY_W-1:0]       filled;
  logic [COST_W-1:0]      cost;
  logic [COST_W-1:0]      product;
  logic [CNT_W-1:0]       idx;

  // divider state
  logic [QTY_W-1:0]       div_rem;
  logic [AVG_W-1:0]       div_dvd;
  logic [DIV_CNT_W-1:0]   div_cnt;

  // level valid bits, an unwritten level reads as zero
  logic [BOOK_LEVELS-1:0] ask_vld;
  logic [BOOK_LEVELS-1:0] bid_vld;
  logic                   rd_vld;

  logic                   in_range;
  logic [LVL_W-1:0]       waddr;
  logic [LVL_W-1:0]       raddr;
  level_t                 wlevel;
  level_t                 ask_rdata;
  level_t                 bid_rdata;
  level_t                 lvl;
  logic [QTY_W-1:0]       avail;
  logic [PRICE_W-1:0]     lvl_price;
  logic [QTY_W-1:0]       take;
  logic [QTY_W:0]         trial;
  logic [QTY_W:0]         diff;
  logic                   ge;

  // level write decode
  assign in_range      = 32'(level_index) < 32'(BOOK_LEVELS);
  assign waddr         = LVL_W'(level_index);
  assign raddr         = idx[LVL_W-1:0];
  assign wlevel.price  = price_ticks;
  assign wlevel.quantity = quantity;

  mobw_ram #(.WIDTH($bits(level_t)), .DEPTH(BOOK_LEVELS)) ask_ram (
    .clk   (clk),
    .we    (cmd.write_ask && in_range),
    .waddr (waddr),
    .wdata (wlevel),
    .raddr (raddr),
    .rdata (ask_rdata)
  );

  mobw_ram #(.WIDTH($bits(level_t)), .DEPTH(BOOK_LEVELS)) bid_ram (
    .clk   (clk),
    .we    (cmd.write_bid && in_range),
    .waddr (waddr),
    .wdata (wlevel),
    .raddr (raddr),
    .rdata (bid_rdata)
  );

  // valid bits track written levels
  always_ff @(posedge clk) begin
    if (rst) begin
      ask_vld <= '0;
      bid_vld <= '0;
    end else begin
      if (cmd.write_ask && in_range) begin
        ask_vld[waddr] <= 1'b1;
      end
      if (cmd.write_bid && in_range) begin
        bid_vld[waddr] <= 1'b1;
      end
    end
  end

  // valid bit is registered alongside the ram read
  always_ff @(posedge clk) begin
    rd_vld <= side_q ? bid_vld[raddr] : ask_vld[raddr];
  end

  // level seen by the walk, lesser of available and remaining
  assign lvl       = side_q ? bid_rdata : ask_rdata;
  assign avail     = rd_vld ? lvl.quantity : '0;
  assign lvl_price = rd_vld ? lvl.price : '0;
  assign take      = (avail < remaining) ? avail : remaining;

  // walk registers
  always_ff @(posedge clk) begin
    if (cmd.load_order) begin
      side_q    <= side;
      tag_q     <= order_tag;
      remaining <= quantity;
      filled    <= '0;
      cost      <= '0;
      idx       <= '0;
    end else begin
      if (cmd.take) begin
        product   <= COST_W'(take) * COST_W'(lvl_price);
        filled    <= filled + take;
        remaining <= remaining - take;
        idx       <= idx + 1'b1;
      end
      if (cmd.accum) begin
        cost <= cost + product;
      end
    end
  end

  // restoring divider, one quotient bit per cycle
  assign trial = {div_rem, div_dvd[AVG_W-1]};
  assign diff  = trial - {1'b0, filled};
  assign ge    = trial >= {1'b0, filled};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      div_rem <= cost[COST_W-1:AVG_W];
      div_dvd <= cost[AVG_W-1:0];
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_rem <= ge ? diff[QTY_W-1:0] : trial[QTY_W-1:0];
      div_dvd <= {div_dvd[AVG_W-2:0], ge};
      div_cnt <= div_cnt + 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      fill_tag        <= tag_q;
      fill_side       <= side_q;
      filled_quantity <= filled;
      fill_cost       <= COST_OUT_W'(cost);
      if (filled == '0) begin
        average_price <= '0;
        fill_status   <= FILL_NONE;
      end else begin
        average_price <= div_dvd;
        fill_status   <= (remaining == '0) ? FILL_FULL : FILL_PARTIAL;
      end
    end
  end

  // status to controller
  assign status.remaining_zero = remaining == '0;
  assign status.walk_end       = idx == CNT_W'(BOOK_LEVELS);
  assign status.filled_zero    = filled == '0;
  assign status.div_last       = div_cnt == DIV_CNT_W'(AVG_W - 1);

endmodule

@@ src/mobw_ctrl.sv @@
module mobw_ctrl import mobw_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [OP_W-1:0] op,
  output logic            out_valid,
  input  logic            out_ready,
  output ctrl_cmd_t       cmd,
  input  dp_status_t      status
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_READ = 6'b000010,
    S_MUL  = 6'b000100,
    S_ACC  = 6'b001000,
    S_DIV  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_ready = state == S_IDLE;
  assign accept   = in_valid && in_ready;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        cmd.write_ask  = accept && (op == OP_WRITE_ASK);
        cmd.write_bid  = accept && (op == OP_WRITE_BID);
        cmd.load_order = accept && (op == OP_MARKET);
        if (cmd.load_order) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        if (status.remaining_zero || status.walk_end) begin
          if (status.filled_zero) begin
            state_next = S_DONE;
          end else begin
            cmd.div_init = 1'b1;
            state_next   = S_DIV;
          end
        end else begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.take   = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.accum  = 1'b1;
        state_next = S_READ;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

@@ src/market_order_book_walk_vwap_unit.sv @@
// Order book with market-order walk. Level writes (op 0 asks, op 1 bids) give no result;
// a write beyond the book or op 3 is dropped. A market order (op 2) walks the opposite
// side from the best level, through a ram read, a 24x32 multiply and an accumulate for
// each level visited, stopping when filled or at the last level, then runs a restoring
// divider for the average price unless nothing filled. The book is not consumed, and
// starts all zero after reset. The result sits in an output register, so writes may be
// accepted while it waits to be taken.
module market_order_book_walk_vwap_unit import mobw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [OP_W-1:0]       op,
  input  logic                  side,
  input  logic [IDX_W-1:0]      level_index,
  input  logic [PRICE_W-1:0]    price_ticks,
  input  logic [QTY_W-1:0]      quantity,
  input  logic [TAG_W-1:0]      order_tag,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [TAG_W-1:0]      fill_tag,
  output logic                  fill_side,
  output logic [QTY_W-1:0]      filled_quantity,
  output logic [COST_OUT_W-1:0] fill_cost,
  output logic [AVG_W-1:0]      average_price,
  output logic [STATUS_W-1:0]   fill_status
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // sequencer
  mobw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  // book, walk and divider
  mobw_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .side            (side),
    .level_index     (level_index),
    .price_ticks     (price_ticks),
    .quantity        (quantity),
    .order_tag       (order_tag),
    .fill_tag        (fill_tag),
    .fill_side       (fill_side),
    .filled_quantity (filled_quantity),
    .fill_cost       (fill_cost),
    .average_price   (average_price),
    .fill_status     (fill_status)
  );

endmodule

@@ bench/tb_market_order_book_walk_vwap_unit.sv @@
`timescale 1ns / 1ps

module tb_market_order_book_walk_vwap_unit;
  import mobw_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int IDLE_LIMIT = 2000;
  localparam int TAIL_CYCLES = 100;
  localparam int RANDOM_PER_PHASE = 275;

  // one input item as queued for the driver
  typedef struct {
    logic [OP_W-1:0]    op;
    logic               side;
    logic [IDX_W-1:0]   idx;
    logic [PRICE_W-1:0] px;
    logic [QTY_W-1:0]   qty;
    logic [TAG_W-1:0]   tag;
  } item_t;

  // one predicted fill report
  typedef struct {
    logic [TAG_W-1:0]      tag;
    logic                  side;
    logic [QTY_W-1:0]      lots;
    logic [COST_OUT_W-1:0] cost;
    logic [AVG_W-1:0]      avg;
    logic [STATUS_W-1:0]   status;
  } fill_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [OP_W-1:0] op = OP_WRITE_ASK;
  logic side = 1'b0;
  logic [IDX_W-1:0] level_index = '0;
  logic [PRICE_W-1:0] price_ticks = '0;
  logic [QTY_W-1:0] quantity = '0;
  logic [TAG_W-1:0] order_tag = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [TAG_W-1:0] fill_tag;
  logic fill_side;
  logic [QTY_W-1:0] filled_quantity;
  logic [COST_OUT_W-1:0] fill_cost;
  logic [AVG_W-1:0] average_price;
  logic [STATUS_W-1:0] fill_status;

  // shadow book
  logic [PRICE_W-1:0] ask_px [BOOK_LEVELS];
  logic [QTY_W-1:0]   ask_lots [BOOK_LEVELS];
  logic [PRICE_W-1:0] bid_px [BOOK_LEVELS];
  logic [QTY_W-1:0]   bid_lots [BOOK_LEVELS];

  item_t item_q[$];
  fill_t fill_q[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int idle_cycles = 0;
  int n_writes = 0;
  int n_full = 0;
  int n_partial = 0;
  int n_empty = 0;

  market_order_book_walk_vwap_unit i_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .op              (op),
    .side            (side),
    .level_index     (level_index),
    .price_ticks     (price_ticks),
    .quantity        (quantity),
    .order_tag       (order_tag),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .fill_tag        (fill_tag),
    .fill_side       (fill_side),
    .filled_quantity (filled_quantity),
    .fill_cost       (fill_cost),
    .average_price   (average_price),
    .fill_status     (fill_status)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < BOOK_LEVELS; i++) begin
      ask_px[i] = '0;
      ask_lots[i] = '0;
      bid_px[i] = '0;
      bid_lots[i] = '0;
    end
  end

  // walk the opposite side of the shadow book for a market order
  function automatic fill_t walk_book(logic s, logic [QTY_W-1:0] want, logic [TAG_W-1:0] tag);
    fill_t f;
    logic [QTY_W-1:0] left, got, lots, take;
    logic [PRICE_W-1:0] px;
    logic [63:0] cost, avg;
    left = want;
    got = '0;
    cost = '0;
    avg = '0;
    for (int i = 0; i < BOOK_LEVELS && left != 0; i++) begin
      lots = s ? bid_lots[i] : ask_lots[i];
      px = s ? bid_px[i] : ask_px[i];
      take = (lots < left) ? lots : left;
      cost = cost + 64'(take) * 64'(px);
      got = got + take;
      left = left - take;
    end
    f.tag = tag;
    f.side = s;
    f.lots = got;
    f.cost = cost[COST_OUT_W-1:0];
    if (got == 0) begin
      f.avg = '0;
      f.status = FILL_NONE;
    end else begin
      avg = cost / 64'(got);
      f.avg = avg[AVG_W-1:0];
      f.status = (left == 0) ? FILL_FULL : FILL_PARTIAL;
    end
    return f;
  endfunction

  // apply an accepted item to the shadow book, queue the fill it causes
  task automatic book_step(item_t it);
    if ((it.op == OP_WRITE_ASK || it.op == OP_WRITE_BID) && int'(it.idx) < BOOK_LEVELS) begin
      n_writes++;
      if (it.op == OP_WRITE_ASK) begin
        ask_px[it.idx] = it.px;
        ask_lots[it.idx] = it.qty;
      end else begin
        bid_px[it.idx] = it.px;
        bid_lots[it.idx] = it.qty;
      end
    end else if (it.op == OP_MARKET) begin
      fill_q.push_back(walk_book(it.side, it.qty, it.tag));
    end
  endtask

  task automatic push_item(logic [OP_W-1:0] o, logic s, logic [IDX_W-1:0] idx,
                           logic [PRICE_W-1:0] px, logic [QTY_W-1:0] qty,
                           logic [TAG_W-1:0] tag);
    item_t it;
    it.op = o;
    it.side = s;
    it.idx = idx;
    it.px = px;
    it.qty = qty;
    it.tag = tag;
    item_q.push_back(it);
  endtask

  // random item: mostly level writes and orders, a few unused op codes
  function automatic item_t rand_item();
    item_t it;
    int pick;
    pick = $urandom_range(99);
    it.side = 1'($urandom_range(1));
    it.idx = IDX_W'($urandom_range(BOOK_LEVELS - 1));
    it.tag = TAG_W'($urandom_range(16'hFFFF));
    case ($urandom_range(9))
      0: it.px = '0;
      1: it.px = '1;
      2, 3, 4, 5: it.px = $urandom_range(1000, 1);
      default: it.px = $urandom;
    endcase
    if (pick < 55) begin
      it.op = (pick < 28) ? OP_WRITE_ASK : OP_WRITE_BID;
      case ($urandom_range(9))
        0: it.qty = '0;
        1: it.qty = '1;
        2, 3, 4, 5, 6: it.qty = QTY_W'($urandom_range(500, 1));
        default: it.qty = QTY_W'($urandom_range(24'hFFFFFF));
      endcase
    end else if (pick < 92) begin
      it.op = OP_MARKET;
      case ($urandom_range(9))
        0: it.qty = '0;
        1: it.qty = '1;
        2, 3, 4, 5, 6: it.qty = QTY_W'($urandom_range(3000, 1));
        7: it.qty = QTY_W'($urandom_range(20, 1));
        default: it.qty = QTY_W'($urandom_range(24'hFFFFFF));
      endcase
    end else begin
      it.op = OP_UNUSED;
      it.qty = QTY_W'($urandom_range(24'hFFFFFF));
    end
    return it;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // driver: present queued items, account for each accepted one
  always @(posedge clk) begin : driver
    logic fire;
    item_t cur, nxt;
    fire = in_valid && in_ready;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (fire) begin
        cur.op = op;
        cur.side = side;
        cur.idx = level_index;
        cur.px = price_ticks;
        cur.qty = quantity;
        cur.tag = order_tag;
        book_step(cur);
      end
      if ((fire || !in_valid) && item_q.size() > 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        nxt = item_q.pop_front();
        in_valid <= 1'b1;
        op <= nxt.op;
        side <= nxt.side;
        level_index <= nxt.idx;
        price_ticks <= nxt.px;
        quantity <= nxt.qty;
        order_tag <= nxt.tag;
      end else if (fire) begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: compare each fill report with the oldest prediction
  always @(posedge clk) begin : monitor
    fill_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (fill_q.size() == 0) begin
          $display("%0t: fill with no order pending, tag %0h", $time, fill_tag);
          mismatches++;
        end else begin
          want = fill_q.pop_front();
          check_field("fill_tag", 64'(want.tag), 64'(fill_tag));
          check_field("fill_side", 64'(want.side), 64'(fill_side));
          check_field("filled_quantity", 64'(want.lots), 64'(filled_quantity));
          check_field("fill_cost", 64'(want.cost), 64'(fill_cost));
          check_field("average_price", 64'(want.avg), 64'(average_price));
          check_field("fill_status", 64'(want.status), 64'(fill_status));
          case (want.status)
            FILL_FULL: n_full++;
            FILL_PARTIAL: n_partial++;
            default: n_empty++;
          endcase
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d cycles with nothing accepted", idle_cycles);
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus: directed book setup and orders, then random phases
  initial begin
    item_t it;
    int n;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < 4; ph++) begin
      @(negedge clk);
      case (ph)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 65;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 65;
        end
        default: begin
          send_idle_pct = 8;
          recv_stall_pct = 8;
        end
      endcase
      if (ph == 0) begin
        // orders against the cleared book
        push_item(OP_MARKET, 1'b0, 4'd0, '0, 24'd100, 16'h0000);
        push_item(OP_MARKET, 1'b1, 4'd15, '1, '1, 16'hFFFF);
        // asks: max level, empty level, zero price, last level
        push_item(OP_WRITE_ASK, 1'b1, 4'd0, '1, '1, 16'h1111);
        push_item(OP_WRITE_ASK, 1'b0, 4'd1, 32'd1000, 24'd0, 16'h0000);
        push_item(OP_WRITE_ASK, 1'b0, 4'd2, 32'd0, 24'd50, 16'h0000);
        push_item(OP_WRITE_ASK, 1'b1, 4'd15, 32'd7, 24'd3, 16'h0000);
        // zero quantity order, then the largest cost
        push_item(OP_MARKET, 1'b0, 4'd0, '0, 24'd0, 16'h0001);
        push_item(OP_MARKET, 1'b0, 4'd9, '1, '1, 16'h0002);
        // walk past the empty level to the end of the book
        push_item(OP_WRITE_ASK, 1'b0, 4'd0, 32'd123, 24'd10, 16'h0000);
        push_item(OP_MARKET, 1'b0, 4'd0, 32'd55, 24'd70, 16'h0003);
        push_item(OP_MARKET, 1'b0, 4'd0, 32'd0, 24'd60, 16'h0004);
        // bids, side ignored on writes
        push_item(OP_WRITE_BID, 1'b0, 4'd0, 32'd500, 24'd40, 16'hFFFF);
        push_item(OP_WRITE_BID, 1'b1, 4'd15, '1, '1, 16'h0000);
        push_item(OP_MARKET, 1'b1, 4'd0, '0, '1, 16'h0005);
        push_item(OP_MARKET, 1'b1, 4'd0, '0, 24'd20, 16'h0006);
        // unused op code must leave the book alone
        push_item(OP_UNUSED, 1'b1, 4'd15, '1, '1, 16'hFFFF);
        push_item(OP_UNUSED, 1'b0, 4'd0, '0, '0, 16'h0000);
        push_item(OP_MARKET, 1'b0, 4'd0, '0, 24'd5, 16'h0007);
        push_item(OP_WRITE_BID, 1'b0, 4'd15, 32'd0, 24'd0, 16'h0000);
        push_item(OP_MARKET, 1'b1, 4'd0, '0, '1, 16'hAAAA);
        push_item(OP_WRITE_ASK, 1'b0, 4'd3, 32'd1, 24'd1, 16'h0000);
        push_item(OP_MARKET, 1'b0, 4'd0, '0, 24'd64, 16'h5555);
      end
      n = 0;
      while (n < RANDOM_PER_PHASE) begin
        it = rand_item();
        item_q.push_back(it);
        n++;
      end
      // hold off until the phase has fully drained
      while (item_q.size() != 0 || in_valid || fill_q.size() != 0) @(negedge clk);
    end
    repeat (TAIL_CYCLES) @(negedge clk);
    $display("checked %0d fills (%0d full, %0d partial, %0d empty) over %0d level writes",
             n_full + n_partial + n_empty, n_full, n_partial, n_empty, n_writes);
    $display("idle profiles run: none, sender 65%%, receiver 65%%, both 8%%");
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
